// ===== rtl/pzss_pkg.sv =====
// shared types and constants for the polarizer z-scan sequencer
`timescale 1ns / 1ps
`default_nettype none
package pzss_pkg;

    typedef enum logic [2:0] {
        ACT_CAPTURE  = 3'd0,
        ACT_ANGLE    = 3'd1,
        ACT_Z        = 3'd2,
        ACT_CLOSE    = 3'd3,
        ACT_STARTED  = 3'd4,
        ACT_REFUSED  = 3'd5,
        ACT_FINISHED = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        MODE_ROT   = 2'd0,
        MODE_ROT_Z = 2'd1,
        MODE_Z     = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_SCAN_MODE      = 3'd0;
    localparam logic [2:0] CFG_ROT_STEPS      = 3'd1;
    localparam logic [2:0] CFG_ROT_STEP_SIZE  = 3'd2;
    localparam logic [2:0] CFG_START_ANGLE    = 3'd3;
    localparam logic [2:0] CFG_Z_PLANES       = 3'd4;
    localparam logic [2:0] CFG_Z_STEP_SIZE    = 3'd5;
    localparam logic [2:0] CFG_CAMERA         = 3'd6;
    localparam logic [2:0] CFG_PIEZO          = 3'd7;

    localparam int CFG_DATA_W = 19;
    localparam int ANGLE_W    = 19;
    localparam int ZMOVE_W    = 21;
    localparam int ROT_IDX_W  = 11;
    localparam int SLOTS      = 4;

    // millidegrees in one turn
    localparam logic [19:0] FULL_TURN  = 20'd360000;
    // largest z return magnitude that the signed field holds
    localparam logic [20:0] Z_RET_MAX  = 21'd1048576;

endpackage
`default_nettype wire

// ===== rtl/polarizer_z_scan_sequencer.sv =====
// polarizer z-scan sequencer: command decode, scan state and result bank
`timescale 1ns / 1ps
`default_nettype none
// Takes start/stop toggles and scan ticks and answers each with zero to four
// result beats (captures, angle and z moves, close file, started, refused,
// finished). An accepted item is held in the input register, is
// decoded there in a single pass against the scan state, and its results are
// loaded at once into a four-entry result bank that drains one beat per cycle
// while i_out_ready is high. The next item is decoded in the cycle the
// previous item's last beat leaves, so an item's results never overwrite
// beats still waiting in the bank. Configuration is one write per cycle and
// is always ready.
module polarizer_z_scan_sequencer #(
    parameter int MAX_ROTATION_STEPS = 1000,
    parameter int MAX_Z_PLANES       = 200
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // item input
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_cmd,
    input  wire logic                    i_camera_busy,
    // result output
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output pzss_pkg::t_action            o_action,
    output logic [18:0]                  o_angle,
    output logic signed [20:0]           o_z_move,
    output logic                         o_last,
    // configuration writes
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [18:0]             i_cfg_data
);
    import pzss_pkg::*;

    localparam logic [11:0] MaxRot    = 12'(MAX_ROTATION_STEPS);
    localparam logic [7:0]  MaxPlanes = 8'(MAX_Z_PLANES);

    // configuration registers
    t_mode        r_mode;
    logic [9:0]   r_rot_steps;
    logic [16:0]  r_rot_step_size;
    logic [18:0]  r_start_angle;
    logic [7:0]   r_z_planes;
    logic [12:0]  r_z_step_size;
    logic         r_camera;
    logic         r_piezo;

    // scan state
    logic                  r_scanning,  n_scanning;
    logic [ROT_IDX_W-1:0]  r_rot_idx,   n_rot_idx;
    logic [7:0]            r_plane_idx, n_plane_idx;
    logic [18:0]           r_target,    n_target;
    logic                  r_pending,   n_pending;

    // input register
    logic r_in_valid;
    logic r_cmd;
    logic r_busy;

    // result bank
    t_action            r_act [SLOTS];
    logic [18:0]        r_ang [SLOTS];
    logic signed [20:0] r_zm  [SLOTS];
    logic [2:0]         r_num;
    logic [1:0]         r_rd;

    t_action            n_act [SLOTS];
    logic [18:0]        n_ang [SLOTS];
    logic signed [20:0] n_zm  [SLOTS];
    logic [2:0]         n_cnt;

    logic        out_fire;
    logic        bank_free;
    logic        move;

    logic [18:0] start_pos;
    logic [9:0]  steps_used;
    logic [7:0]  planes_used;
    logic [19:0] t_sum;
    logic [18:0] t_next;
    logic [20:0] z_prod;
    logic [20:0] z_dist;
    logic signed [20:0] z_ret;
    logic signed [20:0] z_step;
    logic        rot_mode;

    // emission flags, in output order
    logic        f_cap, f_close, f_ang1, f_zstep, f_zret, f_ang2, f_end;
    logic [18:0] ang1_val;
    t_action     end_act;
    logic        do_finish;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_ROT;
            r_rot_steps     <= 10'd40;
            r_rot_step_size <= 17'd5000;
            r_start_angle   <= 19'd51300;
            r_z_planes      <= 8'd1;
            r_z_step_size   <= 13'd5000;
            r_camera        <= 1'b1;
            r_piezo         <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCAN_MODE:     r_mode          <= t_mode'(i_cfg_data[1:0]);
                CFG_ROT_STEPS:     r_rot_steps     <= i_cfg_data[9:0];
                CFG_ROT_STEP_SIZE: r_rot_step_size <= i_cfg_data[16:0];
                CFG_START_ANGLE:   r_start_angle   <= i_cfg_data;
                CFG_Z_PLANES:      r_z_planes      <= i_cfg_data[7:0];
                CFG_Z_STEP_SIZE:   r_z_step_size   <= i_cfg_data[12:0];
                CFG_CAMERA:        r_camera        <= i_cfg_data[0];
                CFG_PIEZO:         r_piezo         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake between input register and result bank
    assign o_out_valid = (r_num != 3'd0);
    assign o_last      = (({1'b0, r_rd} + 3'd1) == r_num);
    assign out_fire    = o_out_valid && i_out_ready;
    assign bank_free   = !o_out_valid || (out_fire && o_last);
    assign move        = r_in_valid && bank_free;
    assign o_in_ready  = !r_in_valid || move;

    assign o_action = r_act[r_rd];
    assign o_angle  = r_ang[r_rd];
    assign o_z_move = r_zm[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_busy <= i_camera_busy;
        end
    end

    // derived quantities
    assign start_pos   = (r_start_angle >= FULL_TURN[18:0])
                         ? 19'(r_start_angle - FULL_TURN[18:0]) : r_start_angle;
    assign steps_used  = ({2'b0, r_rot_steps} > MaxRot) ? MaxRot[9:0] : r_rot_steps;
    assign planes_used = (r_z_planes > MaxPlanes) ? MaxPlanes : r_z_planes;
    assign t_sum       = {1'b0, r_target} + {3'b0, r_rot_step_size};
    assign t_next      = (t_sum >= FULL_TURN) ? 19'(t_sum - FULL_TURN) : t_sum[18:0];
    assign z_prod      = {13'd0, planes_used - 8'd1} * {8'd0, r_z_step_size};
    assign z_dist      = (z_prod > Z_RET_MAX) ? Z_RET_MAX : z_prod;
    assign z_ret       = $signed(21'(~z_dist + 21'd1));
    assign z_step      = $signed({8'b0, r_z_step_size});
    assign rot_mode    = (r_mode == MODE_ROT) || (r_mode == MODE_ROT_Z);

    // decode of the registered item against the scan state
    always_comb begin
        n_scanning  = r_scanning;
        n_rot_idx   = r_rot_idx;
        n_plane_idx = r_plane_idx;
        n_target    = r_target;
        n_pending   = r_pending;
        f_cap       = 1'b0;
        f_close     = 1'b0;
        f_ang1      = 1'b0;
        f_zstep     = 1'b0;
        f_zret      = 1'b0;
        f_ang2      = 1'b0;
        f_end       = 1'b0;
        ang1_val    = start_pos;
        end_act     = ACT_FINISHED;
        do_finish   = 1'b0;

        if (r_cmd) begin
            if (r_scanning && r_camera) begin
                if (r_pending) begin
                    do_finish = 1'b1;
                end else if (rot_mode) begin
                    if (r_rot_idx <= {1'b0, steps_used}) begin
                        n_target  = t_next;
                        f_cap     = 1'b1;
                        f_ang1    = 1'b1;
                        ang1_val  = t_next;
                        n_rot_idx = r_rot_idx + 1'b1;
                    end else if (r_mode == MODE_ROT_Z && r_plane_idx < planes_used) begin
                        f_close     = 1'b1;
                        n_target    = start_pos;
                        f_ang1      = 1'b1;
                        n_rot_idx   = ROT_IDX_W'(1);
                        f_zstep     = r_piezo;
                        n_plane_idx = r_plane_idx + 8'd1;
                    end else begin
                        do_finish = 1'b1;
                    end
                end else if (r_mode == MODE_Z) begin
                    if (r_plane_idx <= planes_used) begin
                        f_cap = 1'b1;
                        if (r_plane_idx < planes_used) begin
                            f_zstep     = r_piezo;
                            n_plane_idx = r_plane_idx + 8'd1;
                        end else begin
                            n_pending = 1'b1;
                        end
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
        end else if (r_scanning) begin
            do_finish = 1'b1;
        end else begin
            f_ang2 = rot_mode;
            f_end  = 1'b1;
            if (r_busy) begin
                end_act = ACT_REFUSED;
            end else begin
                end_act     = ACT_STARTED;
                n_rot_idx   = ROT_IDX_W'(1);
                n_plane_idx = 8'd1;
                n_target    = start_pos;
                n_pending   = 1'b0;
                n_scanning  = 1'b1;
            end
        end

        if (do_finish) begin
            f_zret     = (r_mode == MODE_ROT_Z || r_mode == MODE_Z) && r_piezo
                         && (planes_used > 8'd1);
            f_ang2     = rot_mode;
            f_end      = 1'b1;
            end_act    = ACT_FINISHED;
            n_scanning = 1'b0;
            n_pending  = 1'b0;
        end
    end

    // pack the flagged results into bank slots in order
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_act[i] = ACT_CAPTURE;
            n_ang[i] = 19'd0;
            n_zm[i]  = 21'sd0;
        end
        n_cnt = 3'd0;
        if (f_cap) begin
            n_cnt = 3'd3;
        end
        if (f_close) begin
            n_act[n_cnt[1:0]] = ACT_CLOSE;
            n_cnt = n_cnt + 3'd1;
        end
        if (f_ang1) begin
            n_act[n_cnt[1:0]] = ACT_ANGLE;
            n_ang[n_cnt[1:0]] = ang1_val;
            n_cnt = n_cnt + 3'd1;
        end
        if (f_zstep) begin
            n_act[n_cnt[1:0]] = ACT_Z;
            n_zm[n_cnt[1:0]]  = z_step;
            n_cnt = n_cnt + 3'd1;
        end
        if (f_zret) begin
            n_act[n_cnt[1:0]] = ACT_Z;
            n_zm[n_cnt[1:0]]  = z_ret;
            n_cnt = n_cnt + 3'd1;
        end
        if (f_ang2) begin
            n_act[n_cnt[1:0]] = ACT_ANGLE;
            n_ang[n_cnt[1:0]] = start_pos;
            n_cnt = n_cnt + 3'd1;
        end
        if (f_end) begin
            n_act[n_cnt[1:0]] = end_act;
            n_cnt = n_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning  <= 1'b0;
            r_rot_idx   <= '0;
            r_plane_idx <= 8'd1;
            r_target    <= 19'd0;
            r_pending   <= 1'b0;
        end else if (move) begin
            r_scanning  <= n_scanning;
            r_rot_idx   <= n_rot_idx;
            r_plane_idx <= n_plane_idx;
            r_target    <= n_target;
            r_pending   <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 3'd0;
            r_rd  <= 2'd0;
        end else if (move) begin
            r_num <= n_cnt;
            r_rd  <= 2'd0;
        end else if (out_fire) begin
            if (o_last) begin
                r_num <= 3'd0;
                r_rd  <= 2'd0;
            end else begin
                r_rd <= r_rd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_act[i] <= n_act[i];
                r_ang[i] <= n_ang[i];
                r_zm[i]  <= n_zm[i];
            end
        end
    end

`ifndef SYNTHESIS
    // an item's beats come without a gap until its last one
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |=> o_out_valid)
        else $error("result burst broken before last beat");

    a_bank_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_num <= 3'd4) && (!o_out_valid || ({1'b0, r_rd} < r_num)))
        else $error("result bank count out of range");

    a_angle_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_ANGLE) |-> ({1'b0, o_angle} < FULL_TURN))
        else $error("angle beat not below a full turn");

    a_z_only_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_Z) |-> (o_z_move == 21'sd0))
        else $error("z distance on a beat that is not a z move");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_scanning))
        else $error("output or scan active after reset");
`endif

endmodule
`default_nettype wire
